/* rtl/rsd_pkg.sv */
`timescale 1ns / 1ps
package rsd_pkg;

	localparam int RSD_MAX_WIDTH   = 4096;
	localparam int RSD_QUEUE_DEPTH = 2;
	localparam int RSD_COL_W       = 13;

	// result status codes
	localparam logic [2:0] STATUS_TAKEN   = 3'd0;
	localparam logic [2:0] STATUS_READY   = 3'd1;
	localparam logic [2:0] STATUS_REFUSED = 3'd2;
	localparam logic [2:0] STATUS_PIXEL   = 3'd3;
	localparam logic [2:0] STATUS_NONE    = 3'd4;

	// item commands
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] red_float;
		logic [31:0] green_float;
		logic [31:0] blue_float;
		logic        last_of_row;
		logic        last_of_image;
	} result_t;

	// one rgbe channel to an ieee single, value = m * 2^(e - 136)
	function automatic logic [31:0] rgbe_to_float(input logic [7:0] m, input logic [7:0] e);
		logic [2:0]  p;
		logic [8:0]  biased;
		logic [31:0] r;
		logic [22:0] frac;
		p = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (m[i]) p = 3'(i);
		end
		biased = 9'({1'b0, e}) + 9'(p) - 9'd9;
		frac = 23'({m, 15'b0} << (4'd8 - 4'(p)));
		if (e == 8'd0 || m == 8'd0) begin
			r = 32'd0;
		end else if (!biased[8] && biased != 9'd0) begin
			r = {1'b0, biased[7:0], frac};
		end else begin
			r = 32'(m) << (e[4:0] + 5'd13);
		end
		return r;
	endfunction

endpackage

/* rtl/rsd_item_queue.sv */
`timescale 1ns / 1ps
module rsd_item_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsd_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output rsd_pkg::item_t head_item,
	output logic           head_valid
);
	import rsd_pkg::*;

	localparam int PW = (RSD_QUEUE_DEPTH > 1) ? $clog2(RSD_QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(RSD_QUEUE_DEPTH + 1);

	item_t          slot_q [RSD_QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == CW'(RSD_QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(RSD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(RSD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(RSD_QUEUE_DEPTH)) else $error("queue overfilled");
	a_empty_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 && !push) |=> (count_q == '0)) else $error("queue level moved");
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue lost a push");

endmodule

/* rtl/rsd_engine.sv */
`timescale 1ns / 1ps
module rsd_engine #(
	parameter int MAX_WIDTH = rsd_pkg::RSD_MAX_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rsd_pkg::item_t   head_item,
	input  logic             head_valid,
	output logic             head_take,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	output rsd_pkg::result_t result,
	output logic             result_valid,
	input  logic             result_pop
);
	import rsd_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);

	localparam logic [1:0] CODE_UNDEC = 2'd0;
	localparam logic [1:0] CODE_RLE   = 2'd1;
	localparam logic [1:0] CODE_FLAT  = 2'd2;
	localparam logic [1:0] PH_COUNT   = 2'd0;
	localparam logic [1:0] PH_RUN     = 2'd1;
	localparam logic [1:0] PH_LIT     = 2'd2;

	typedef enum logic [1:0] {S_IDLE, S_FILL, S_CONV} state_t;

	typedef struct packed {
		logic [31:0] lead;
		logic [2:0]  lead_cnt;
		logic [1:0]  coding;
		logic [1:0]  chan;
		logic [12:0] col;
		logic [1:0]  phase;
		logic [7:0]  left;
		logic [4:0]  shift;
		logic [23:0] gather;
		logic [1:0]  gidx;
	} dec_t;

	// result item carrying only a status code
	function automatic result_t status_only(input logic [2:0] st);
		result_t r;
		r = '0;
		r.status = st;
		return r;
	endfunction

	state_t       state_q;
	dec_t         dec_q, dec_d;
	logic [12:0]  width_q;
	logic [15:0]  height_q;
	logic [12:0]  w_eff;
	logic [15:0]  h_eff;
	logic         row_ready_q;
	logic [12:0]  fetch_col_q;
	logic [15:0]  row_num_q;
	logic [31:0]  last_px_q, last_px_d;
	logic [12:0]  fill_col_q, fill_col_d;
	logic [12:0]  fill_cnt_q, fill_cnt_d;
	logic [31:0]  fill_data_q, fill_data_d;
	logic [3:0]   fill_mask_q, fill_mask_d;
	logic         fill_go;
	logic         done;
	logic         pend_lr_q, pend_li_q;
	logic [7:0]   rd_q [4];
	logic [7:0]   bank_mem [4][MAX_WIDTH];
	logic         cfg_we;
	logic         take_push, take_fetch, rd_en;
	logic [7:0]   b;
	logic [31:0]  lead_all;
	logic [12:0]  rem, n_run, col_n;
	logic [31:0]  run32;
	logic         lr, li;

	// effective geometry
	always_comb begin
		if (width_q == 13'd0) w_eff = 13'd1;
		else if (32'(width_q) > MAX_WIDTH) w_eff = 13'(MAX_WIDTH);
		else w_eff = width_q;
		h_eff = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	assign cfg_ready    = 1'b1;
	assign cfg_we       = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
	assign head_take    = (state_q == S_IDLE) && head_valid && !result_valid && !cfg_we;
	assign take_push    = head_take && (head_item.command == CMD_PUSH) && !row_ready_q;
	assign take_fetch   = head_take && (head_item.command == CMD_FETCH) && row_ready_q;
	assign rd_en        = take_fetch;
	assign b            = head_item.data_byte;
	assign lead_all     = {b, dec_q.lead[23:0]};
	assign rem          = w_eff - dec_q.col;
	assign lr           = (14'(fetch_col_q) + 14'd1) >= 14'(w_eff);
	assign li           = lr && ((17'(row_num_q) + 17'd1) >= 17'(h_eff));

	// byte decode for the current row coding
	always_comb begin
		dec_d       = dec_q;
		last_px_d   = last_px_q;
		fill_go     = 1'b0;
		fill_col_d  = dec_q.col;
		fill_cnt_d  = 13'd1;
		fill_data_d = {4{b}};
		fill_mask_d = 4'b1111;
		done        = 1'b0;
		n_run       = 13'd0;
		col_n       = dec_q.col;
		run32       = 32'(b) << dec_q.shift;
		case (dec_q.coding)
			CODE_UNDEC: begin
				dec_d.lead     = dec_q.lead | (32'(b) << {dec_q.lead_cnt[1:0], 3'b000});
				dec_d.lead_cnt = dec_q.lead_cnt + 3'd1;
				if (dec_q.lead_cnt[1:0] == 2'd3) begin
					if (lead_all[15:0] == 16'h0202 &&
						{3'b000, lead_all[23:16], lead_all[31:24]} == {6'b0, w_eff} &&
						w_eff >= 13'd8) begin
						dec_d.coding = CODE_RLE;
						dec_d.chan   = 2'd0;
						dec_d.col    = 13'd0;
						dec_d.phase  = PH_COUNT;
						dec_d.left   = 8'd0;
					end else begin
						dec_d.coding = CODE_FLAT;
						fill_go      = 1'b1;
						fill_col_d   = 13'd0;
						fill_data_d  = lead_all;
						last_px_d    = lead_all;
						dec_d.col    = 13'd1;
						dec_d.shift  = 5'd0;
						done         = (w_eff <= 13'd1);
					end
				end
			end
			CODE_RLE: begin
				if (dec_q.phase == PH_COUNT) begin
					if (b > 8'd128) begin
						dec_d.left  = b - 8'd128;
						dec_d.phase = PH_RUN;
					end else if (b != 8'd0) begin
						dec_d.left  = b;
						dec_d.phase = PH_LIT;
					end
				end else begin
					fill_go     = 1'b1;
					fill_mask_d = 4'b0001 << dec_q.chan;
					if (dec_q.phase == PH_RUN) begin
						n_run       = (13'(dec_q.left) > rem) ? rem : 13'(dec_q.left);
						fill_cnt_d  = n_run;
						col_n       = dec_q.col + n_run;
						dec_d.left  = 8'd0;
						dec_d.phase = PH_COUNT;
					end else begin
						col_n      = dec_q.col + 13'd1;
						dec_d.left = dec_q.left - 8'd1;
						if (dec_q.left == 8'd1) dec_d.phase = PH_COUNT;
					end
					dec_d.col = col_n;
					// channel ends at the row end
					if (col_n >= w_eff) begin
						dec_d.col   = 13'd0;
						dec_d.phase = PH_COUNT;
						dec_d.left  = 8'd0;
						if (dec_q.chan == 2'd3) done = 1'b1;
						else dec_d.chan = dec_q.chan + 2'd1;
					end
				end
			end
			CODE_FLAT: begin
				if (dec_q.gidx != 2'd3) begin
					dec_d.gather = dec_q.gather | (24'(b) << {dec_q.gidx, 3'b000});
					dec_d.gidx   = dec_q.gidx + 2'd1;
				end else begin
					dec_d.gather = 24'd0;
					dec_d.gidx   = 2'd0;
					// repeat marker copies the previous pixel
					if (dec_q.gather == 24'h010101 && dec_q.col != 13'd0) begin
						n_run       = (run32 > 32'(rem)) ? rem : run32[12:0];
						fill_go     = (n_run != 13'd0);
						fill_cnt_d  = n_run;
						fill_data_d = last_px_q;
						col_n       = dec_q.col + n_run;
						dec_d.shift = (dec_q.shift >= 5'd24) ? 5'd24 : dec_q.shift + 5'd8;
					end else begin
						fill_go     = 1'b1;
						fill_data_d = {b, dec_q.gather};
						last_px_d   = {b, dec_q.gather};
						col_n       = dec_q.col + 13'd1;
						dec_d.shift = 5'd0;
					end
					dec_d.col = col_n;
					done      = (col_n >= w_eff);
				end
			end
			default: ;
		endcase
		if (done) dec_d = '0;
	end

	// control sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			dec_q        <= '0;
			width_q      <= 13'd1;
			height_q     <= 16'd1;
			row_ready_q  <= 1'b0;
			fetch_col_q  <= 13'd0;
			row_num_q    <= 16'd0;
			result_valid <= 1'b0;
			result       <= '0;
			pend_lr_q    <= 1'b0;
			pend_li_q    <= 1'b0;
			fill_cnt_q   <= 13'd0;
		end else begin
			if (result_valid && result_pop) result_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (head_take) begin
						if (head_item.command == CMD_PUSH) begin
							result_valid <= 1'b1;
							if (row_ready_q) begin
								result <= status_only(STATUS_REFUSED);
							end else begin
								dec_q  <= dec_d;
								result <= status_only(done ? STATUS_READY : STATUS_TAKEN);
								if (done) begin
									row_ready_q <= 1'b1;
									fetch_col_q <= 13'd0;
								end
								if (fill_go) begin
									fill_cnt_q <= fill_cnt_d;
									state_q    <= S_FILL;
								end
							end
						end else if (!row_ready_q) begin
							result_valid <= 1'b1;
							result       <= status_only(STATUS_NONE);
						end else begin
							pend_lr_q <= lr;
							pend_li_q <= li;
							state_q   <= S_CONV;
							if (lr) begin
								row_ready_q <= 1'b0;
								fetch_col_q <= 13'd0;
								row_num_q   <= li ? 16'd0 : row_num_q + 16'd1;
							end else begin
								fetch_col_q <= fetch_col_q + 13'd1;
							end
						end
					end
				end
				S_FILL: begin
					fill_cnt_q <= fill_cnt_q - 13'd1;
					if (fill_cnt_q == 13'd1) state_q <= S_IDLE;
				end
				S_CONV: begin
					result_valid         <= 1'b1;
					result.status        <= STATUS_PIXEL;
					result.red_float     <= rgbe_to_float(rd_q[0], rd_q[3]);
					result.green_float   <= rgbe_to_float(rd_q[1], rd_q[3]);
					result.blue_float    <= rgbe_to_float(rd_q[2], rd_q[3]);
					result.last_of_row   <= pend_lr_q;
					result.last_of_image <= pend_li_q;
					state_q              <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// register write restarts row and image
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) width_q <= cfg_data[12:0];
				else height_q <= cfg_data;
				dec_q       <= '0;
				row_ready_q <= 1'b0;
				fetch_col_q <= 13'd0;
				row_num_q   <= 16'd0;
			end
		end
	end

	// fill payload
	always_ff @(posedge clk) begin
		if (take_push) begin
			last_px_q <= last_px_d;
			if (fill_go) begin
				fill_col_q  <= fill_col_d;
				fill_data_q <= fill_data_d;
				fill_mask_q <= fill_mask_d;
			end
		end else if (state_q == S_FILL) begin
			fill_col_q <= fill_col_q + 13'd1;
		end
	end

	// line store, one bank per channel
	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			if (state_q == S_FILL && fill_mask_q[c]) begin
				bank_mem[c][AW'(fill_col_q)] <= fill_data_q[8*c +: 8];
			end
			if (rd_en) rd_q[c] <= bank_mem[c][AW'(fetch_col_q)];
		end
	end

	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (fill_cnt_q != 13'd0)) else $error("empty fill");
	a_ready_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		row_ready_q |-> (dec_q.coding == CODE_UNDEC && dec_q.lead_cnt == 3'd0))
		else $error("decoder not cleared at row end");
	a_fetch_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_ready_q |-> (fetch_col_q < w_eff)) else $error("fetch past row end");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_pop) |=> (result_valid && $stable(result)))
		else $error("waiting result changed");

endmodule

/* rtl/rgbe_scanline_rle_decoder_core.sv */
`timescale 1ns / 1ps
// RGBE scanline decoder. Items enter through a queue port (push/full) and
// carry either one coded scanline byte or a fetch command. Results leave
// through a queue port (empty/pop), one per item, in item order.
// A two-entry input queue sits in front of a sequencer that decodes each
// byte into a four-bank line store (one bank per channel).
// A byte that writes no store entry has its result registered when the
// sequencer takes it; a byte that writes pixels (run or repeat) gives its
// result at once and then holds the sequencer while it writes them to the
// store. A fetch goes through a registered store read, then float
// conversion into the result register. The sequencer takes the next item
// only once the previous result is popped.
// The configuration port (cfg_valid/cfg_ready, always ready) writes image
// width (index 0) and height (index 1); a write restarts the row and image.
// Reset empties the input queue and the result register and clears decode
// state; the line store is not cleared. When the receiver stalls, the result
// waits in the output register while the input queue keeps taking items
// until full.
module rgbe_scanline_rle_decoder_core #(
	parameter int MAX_WIDTH = rsd_pkg::RSD_MAX_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rsd_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output rsd_pkg::result_t result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import rsd_pkg::*;

	item_t head_item;
	logic  head_valid;
	logic  head_take;
	logic  result_valid;

	assign empty = !result_valid;

	rsd_item_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (item),
		.full       (full),
		.pop        (head_take),
		.head_item  (head_item),
		.head_valid (head_valid)
	);

	rsd_engine #(.MAX_WIDTH(MAX_WIDTH)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (head_item),
		.head_valid   (head_valid),
		.head_take    (head_take),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result       (result),
		.result_valid (result_valid),
		.result_pop   (pop)
	);

endmodule
